### sv/tabular_q_learning_engine_unit_macros.svh
// assertion macros used by the top-level rtl file
`ifndef TABULAR_Q_LEARNING_ENGINE_UNIT_MACROS_SVH
`define TABULAR_Q_LEARNING_ENGINE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TQLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TQLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TQLE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TQLE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/tqle_pkg.sv
// ----------------------------------------------------------------------------
// tqle_pkg
// types, sizes and helpers of the q-learning engine
// ----------------------------------------------------------------------------
package tqle_pkg;

  localparam int NUM_LUX_LEVELS   = 8;
  localparam int NUM_TIME_PERIODS = 8;
  localparam int NUM_SEASONS      = 4;
  localparam int NUM_LED_LEVELS   = 8;
  localparam int NUM_ACTIONS      = 8;
  localparam int STORE_DEPTH = NUM_LUX_LEVELS * NUM_TIME_PERIODS * NUM_SEASONS *
                               NUM_LED_LEVELS * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  // scan counter also holds the extra slot for the current entry
  localparam int SCAN_W = $clog2(NUM_ACTIONS + 1);
  // update pipeline depth after the scan
  localparam int CALC_CYC = 4;
  localparam int CFG_IDX_W = 3;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE       = 3'd0,
    CFG_DISCOUNT        = 3'd1,
    CFG_EPSILON_PERCENT = 3'd2,
    CFG_LUX_SETPOINT    = 3'd3,
    CFG_LUX_SCALE_RECIP = 3'd4,
    CFG_POWER_WEIGHT    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  lux_level;
    logic [2:0]  time_period;
    logic [1:0]  season;
    logic [2:0]  led_setting;
    logic [2:0]  action;
    logic [6:0]  explore_draw;
    logic [15:0] measured_lux;
    logic [7:0]  pwm_duty;
    logic [2:0]  next_lux_level;
    logic [2:0]  next_time_period;
    logic [1:0]  next_season;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         chosen_action;
    logic               explored;
    logic signed [31:0] reward_value;
    logic signed [31:0] new_q;
  } out_item_t;

  typedef struct packed {
    logic [15:0] step_size;
    logic [15:0] discount;
    logic [6:0]  epsilon_percent;
    logic [15:0] lux_setpoint;
    logic [15:0] lux_scale_recip;
    logic [31:0] power_weight;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              clr_step;
    logic              rd_en;
    logic [SCAN_W-1:0] rd_cnt;
    logic              wr_en;
    logic              emit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic learn;
    logic explore;
  } sts_t;

  function automatic int unsigned clamp_idx(int unsigned v, int unsigned n);
    return (v >= n) ? n - 1 : v;
  endfunction

  function automatic addr_t row_base(int unsigned l, int unsigned t, int unsigned s,
                                     int unsigned led);
    return addr_t'((((l * NUM_TIME_PERIODS + t) * NUM_SEASONS + s) * NUM_LED_LEVELS + led)
                   * NUM_ACTIONS);
  endfunction

endpackage

### sv/tabular_q_learning_engine_unit.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_engine_unit
// epsilon-greedy action choice and q-learning update over a q table
//
//   channel  ports                                  handshake
//   input    start, busy, in_data                   start & !busy
//   result   out_valid, out_data                    one-cycle strobe
//   config   cfg_valid, cfg_ready, cfg_index,       cfg_valid & cfg_ready
//            cfg_wdata
//
// after reset all 16384 table entries are cleared one entry per cycle, with
// busy high; config writes are taken meanwhile
// explore choice: no table read, the result is strobed after the check
// greedy choice: eight reads of the row on the single table read port
// learn: nine table reads, four update stages and the write-back
// results cannot be stalled; busy drops as the result is issued
// ----------------------------------------------------------------------------
`include "tabular_q_learning_engine_unit_macros.svh"

module tabular_q_learning_engine_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  tqle_pkg::in_item_t             in_data,
  output logic                           out_valid,
  output tqle_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tqle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  tqle_pkg::cfg_t cfg;
  tqle_pkg::ctl_t ctl;
  tqle_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // configuration registers
  tqle_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // sequencer
  tqle_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // datapath
  tqle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // checks
  `TQLE_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `TQLE_ASSERT_IMP(a_result_after_work, clk, rst_n, out_valid, $past(busy))
  `TQLE_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `TQLE_ASSERT_IMP(a_no_write_when_idle, clk, rst_n, !busy, !ctl.wr_en && !ctl.clr_step)

endmodule

### sv/tqle_cfg.sv
// ----------------------------------------------------------------------------
// tqle_cfg
// configuration register file, written one register per transaction
// ----------------------------------------------------------------------------
module tqle_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tqle_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]                    wr_data,
  output tqle_pkg::cfg_t                 cfg
);

  tqle_pkg::cfg_t cfg_r, cfg_nxt;

  // register decode, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (tqle_pkg::cfg_idx_t'(wr_index))
        tqle_pkg::CFG_STEP_SIZE:       cfg_nxt.step_size       = wr_data[15:0];
        tqle_pkg::CFG_DISCOUNT:        cfg_nxt.discount        = wr_data[15:0];
        tqle_pkg::CFG_EPSILON_PERCENT: cfg_nxt.epsilon_percent = wr_data[6:0];
        tqle_pkg::CFG_LUX_SETPOINT:    cfg_nxt.lux_setpoint    = wr_data[15:0];
        tqle_pkg::CFG_LUX_SCALE_RECIP: cfg_nxt.lux_scale_recip = wr_data[15:0];
        tqle_pkg::CFG_POWER_WEIGHT:    cfg_nxt.power_weight    = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size       <= 16'd6554;
      cfg_r.discount        <= 16'd58982;
      cfg_r.epsilon_percent <= 7'd30;
      cfg_r.lux_setpoint    <= 16'd500;
      cfg_r.lux_scale_recip <= 16'd66;
      cfg_r.power_weight    <= 32'd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/tqle_ctrl.sv
// ----------------------------------------------------------------------------
// tqle_ctrl
// sequencer: table clear, row scan, update wait, write-back, result strobe
// ----------------------------------------------------------------------------
module tqle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  tqle_pkg::sts_t sts,
  output tqle_pkg::ctl_t ctl,
  output logic          busy
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CLEAR = 8'b00000010,
    S_CHECK = 8'b00000100,
    S_SCAN  = 8'b00001000,
    S_DRAIN = 8'b00010000,
    S_CALC  = 8'b00100000,
    S_WRITE = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [tqle_pkg::SCAN_W-1:0] cnt_r, cnt_nxt;
  logic [tqle_pkg::SCAN_W-1:0] last_slot;

  // learn reads the current entry after the next-state row
  assign last_slot = sts.learn ? tqle_pkg::SCAN_W'(tqle_pkg::NUM_ACTIONS)
                               : tqle_pkg::SCAN_W'(tqle_pkg::NUM_ACTIONS - 1);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = (!sts.learn && sts.explore) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_cnt = cnt_r;
        if (cnt_r == last_slot) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = sts.learn ? S_CALC : S_DONE;
      end
      S_CALC: begin
        if (cnt_r == tqle_pkg::SCAN_W'(tqle_pkg::CALC_CYC - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_WRITE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_WRITE: begin
        ctl.wr_en = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ctl.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### sv/tqle_dp.sv
// ----------------------------------------------------------------------------
// tqle_dp
// datapath: q table memory, row scan, reward and update arithmetic
// ----------------------------------------------------------------------------
module tqle_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tqle_pkg::in_item_t  in_data,
  input  tqle_pkg::cfg_t      cfg,
  input  tqle_pkg::ctl_t      ctl,
  output tqle_pkg::sts_t      sts,
  output logic                out_valid,
  output tqle_pkg::out_item_t out_data
);

  localparam logic [tqle_pkg::SCAN_W-1:0] CUR_SLOT = tqle_pkg::SCAN_W'(tqle_pkg::NUM_ACTIONS);

  // latched item and addresses
  tqle_pkg::in_item_t it_r;
  tqle_pkg::addr_t    cur_row_r, nxt_row_r, cur_addr_r;
  tqle_pkg::addr_t    clr_addr_r;
  logic [2:0]         act_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      it_r      <= in_data;
      act_r     <= 3'(tqle_pkg::clamp_idx(32'(in_data.action), tqle_pkg::NUM_ACTIONS));
      cur_row_r <= tqle_pkg::row_base(
          tqle_pkg::clamp_idx(32'(in_data.lux_level), tqle_pkg::NUM_LUX_LEVELS),
          tqle_pkg::clamp_idx(32'(in_data.time_period), tqle_pkg::NUM_TIME_PERIODS),
          tqle_pkg::clamp_idx(32'(in_data.season), tqle_pkg::NUM_SEASONS),
          tqle_pkg::clamp_idx(32'(in_data.led_setting), tqle_pkg::NUM_LED_LEVELS));
      nxt_row_r <= tqle_pkg::row_base(
          tqle_pkg::clamp_idx(32'(in_data.next_lux_level), tqle_pkg::NUM_LUX_LEVELS),
          tqle_pkg::clamp_idx(32'(in_data.next_time_period), tqle_pkg::NUM_TIME_PERIODS),
          tqle_pkg::clamp_idx(32'(in_data.next_season), tqle_pkg::NUM_SEASONS),
          tqle_pkg::clamp_idx(tqle_pkg::clamp_idx(32'(in_data.action),
                                                  tqle_pkg::NUM_ACTIONS),
                              tqle_pkg::NUM_LED_LEVELS));
    end
    if (ctl.load) begin
      cur_addr_r <= tqle_pkg::row_base(
          tqle_pkg::clamp_idx(32'(in_data.lux_level), tqle_pkg::NUM_LUX_LEVELS),
          tqle_pkg::clamp_idx(32'(in_data.time_period), tqle_pkg::NUM_TIME_PERIODS),
          tqle_pkg::clamp_idx(32'(in_data.season), tqle_pkg::NUM_SEASONS),
          tqle_pkg::clamp_idx(32'(in_data.led_setting), tqle_pkg::NUM_LED_LEVELS))
        + tqle_pkg::ADDR_W'(tqle_pkg::clamp_idx(32'(in_data.action),
                                                tqle_pkg::NUM_ACTIONS));
    end
  end

  // clear pointer
  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (ctl.clr_step) clr_addr_r <= clr_addr_r + 1'b1;
  end

  assign sts.clr_last = (clr_addr_r == tqle_pkg::ADDR_W'(tqle_pkg::STORE_DEPTH - 1));
  assign sts.learn    = it_r.cmd;
  assign sts.explore  = (it_r.explore_draw < cfg.epsilon_percent);

  // q table memory
  logic signed [31:0] mem [tqle_pkg::STORE_DEPTH];
  logic signed [31:0] rd_data_r;
  logic signed [31:0] nq_r;
  tqle_pkg::addr_t    rd_addr, wr_addr;
  logic               wr_en;
  logic signed [31:0] wr_data;

  assign rd_addr = (ctl.rd_cnt == CUR_SLOT) ? cur_addr_r
                 : (it_r.cmd ? nxt_row_r : cur_row_r) + tqle_pkg::ADDR_W'(ctl.rd_cnt);
  assign wr_en   = ctl.clr_step | ctl.wr_en;
  assign wr_addr = ctl.clr_step ? clr_addr_r : cur_addr_r;
  assign wr_data = ctl.clr_step ? 32'sd0 : nq_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (ctl.rd_en) rd_data_r <= mem[rd_addr];
  end

  // scan: running max with lowest index on ties, plus current entry
  logic                        tag_vld_r;
  logic [tqle_pkg::SCAN_W-1:0] tag_r;
  logic signed [31:0]          best_q_r, cur_q_r;
  logic [tqle_pkg::SCAN_W-1:0] best_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) tag_vld_r <= 1'b0;
    else tag_vld_r <= ctl.rd_en;
  end

  always_ff @(posedge clk) begin
    tag_r <= ctl.rd_cnt;
    if (tag_vld_r) begin
      if (tag_r == CUR_SLOT) begin
        cur_q_r <= rd_data_r;
      end else if (tag_r == '0 || rd_data_r > best_q_r) begin
        best_q_r <= rd_data_r;
        best_i_r <= tag_r;
      end
    end
  end

  // reward pipeline, fed from the latched item
  logic signed [16:0] lux_diff;
  logic signed [33:0] lux_sq;
  logic [39:0]        pw_prod;
  logic [31:0]        d2_r;
  logic [39:0]        y_r, y2_r;
  logic [47:0]        pen1, pen1_r, pen1b_r, pen1c_r;
  logic [40:0]        ser, rem;
  logic [32:0]        qe_r, qe3_r, pp_r;
  logic [40:0]        rem_r;
  logic [1:0]         corr;
  logic [48:0]        pen;
  logic signed [31:0] reward_r;

  assign lux_diff = $signed({1'b0, it_r.measured_lux}) - $signed({1'b0, cfg.lux_setpoint});
  assign lux_sq   = lux_diff * lux_diff;
  assign pw_prod  = cfg.power_weight * it_r.pwm_duty;
  assign pen1     = d2_r * cfg.lux_scale_recip;
  // x/255 as x/256 * (1 + 1/256 + ...), then a small correction
  assign ser = 41'(y_r) + 41'(y_r >> 8) + 41'(y_r >> 16) + 41'(y_r >> 24) + 41'(y_r >> 32);
  assign rem = 41'(y2_r) - ({qe_r, 8'd0} - 41'(qe_r));
  assign corr = (rem_r >= 41'd510) ? 2'd2 : ((rem_r >= 41'd255) ? 2'd1 : 2'd0);
  assign pen  = 49'(pen1c_r) + 49'(pp_r);

  always_ff @(posedge clk) begin
    d2_r     <= lux_sq[31:0];
    y_r      <= pw_prod + 40'd127;
    pen1_r   <= pen1;
    qe_r     <= ser[40:8];
    y2_r     <= y_r;
    rem_r    <= rem;
    qe3_r    <= qe_r;
    pen1b_r  <= pen1_r;
    pp_r     <= qe3_r + 33'(corr);
    pen1c_r  <= pen1b_r;
    reward_r <= (pen >= 49'h0_8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - pen[31:0]);
  end

  // q update pipeline
  logic signed [48:0] gm, gm_r;
  logic signed [33:0] tgt;
  logic signed [34:0] diff_r;
  logic signed [51:0] prod, prod_r;
  logic signed [36:0] nsum;

  assign gm   = best_q_r * $signed({1'b0, cfg.discount});
  assign tgt  = 34'(reward_r) + 34'(gm_r >>> 16);
  assign prod = diff_r * $signed({1'b0, cfg.step_size});
  assign nsum = 37'(cur_q_r) + 37'(prod_r >>> 16);

  always_ff @(posedge clk) begin
    gm_r   <= gm;
    diff_r <= 35'(tgt) - 35'(cur_q_r);
    prod_r <= prod;
    if (nsum > 37'sd2147483647) nq_r <= 32'sh7fff_ffff;
    else if (nsum < -37'sd2147483648) nq_r <= 32'sh8000_0000;
    else nq_r <= nsum[31:0];
  end

  // result register
  logic                out_valid_r;
  tqle_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= ctl.emit;
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      if (it_r.cmd) begin
        out_data_r.chosen_action <= 3'd0;
        out_data_r.explored      <= 1'b0;
        out_data_r.reward_value  <= reward_r;
        out_data_r.new_q         <= nq_r;
      end else begin
        out_data_r.chosen_action <= sts.explore ? act_r : 3'(best_i_r);
        out_data_r.explored      <= sts.explore;
        out_data_r.reward_value  <= 32'sd0;
        out_data_r.new_q         <= 32'sd0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
